// ----- rtl/core/lsp_pkg.sv -----
// ----------------------------------------------------------------------------
// lsp_pkg: shared types and constants of the line sensor position block
// holds the lane count, register indexes, pattern sets and bit weights
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int unsigned NumLanes = 8;
  localparam int unsigned SampleW  = 17;
  localparam int unsigned SumW     = 8;
  localparam int unsigned MagW     = 7;
  localparam int unsigned CntW     = 4;
  localparam int unsigned DenW     = 3;
  localparam int unsigned ErrW     = 11;

  localparam logic [1:0] RegDirectThr = 2'd0;
  localparam logic [1:0] RegAdcThr    = 2'd1;
  localparam logic [1:0] RegMirror    = 2'd2;

  localparam logic [9:0]  DirectThrRst = 10'd512;
  localparam logic [14:0] AdcThrRst    = 15'd16384;

  localparam logic signed [ErrW-1:0] ErrNone = -11'sd999;
  localparam logic signed [ErrW-1:0] ErrAll  = 11'sd999;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_DIV_START,
    ST_DIV,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic [7:0]             pattern;
    logic signed [SumW-1:0] sum;
    logic [CntW-1:0]        count;
    logic                   light;
  } merge_res_t;

  // centered dark line on light floor
  function automatic logic is_dark_pat(input logic [7:0] p);
    logic r;
    r = 1'b0;
    case (p)
      8'h18, 8'h3C, 8'h0C, 8'h30, 8'h06,
      8'h60, 8'h10, 8'h08, 8'h1C, 8'h38: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // centered light line on dark floor
  function automatic logic is_light_pat(input logic [7:0] p);
    logic r;
    r = 1'b0;
    case (p)
      8'hE7, 8'hC3, 8'hF3, 8'hCF, 8'hF9,
      8'h9F, 8'hEF, 8'hF7, 8'hE3, 8'hC7: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // weight by bit number, bit 0 is +40 and bit 7 is -40
  function automatic logic signed [SumW-1:0] bit_weight(input logic [2:0] idx);
    logic signed [SumW-1:0] w;
    w = '0;
    case (idx)
      3'd0:    w = 8'sd40;
      3'd1:    w = 8'sd30;
      3'd2:    w = 8'sd20;
      3'd3:    w = 8'sd10;
      3'd4:    w = -8'sd10;
      3'd5:    w = -8'sd20;
      3'd6:    w = -8'sd30;
      default: w = -8'sd40;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/lsp_lane.sv -----
// ----------------------------------------------------------------------------
// lsp_lane: one sensor lane
// compares a widened sample against its threshold and holds the hit
// ----------------------------------------------------------------------------
module lsp_lane (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  logic signed [lsp_pkg::SampleW-1:0] sample,
  input  logic signed [lsp_pkg::SampleW-1:0] threshold,
  output logic                               hit
);
  import lsp_pkg::*;

  logic hit_r;
  logic hit_nxt;

  // strict greater-than, both operands already widened
  assign hit_nxt = load ? (sample > threshold) : hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign hit = hit_r;

endmodule

// ----- rtl/core/lsp_merge.sv -----
// ----------------------------------------------------------------------------
// lsp_merge: combines the lane hits
// orders the bits, tracks the background flag, inverts on a light floor, sums the weights
// ----------------------------------------------------------------------------
module lsp_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic                         mirror,
  input  logic [lsp_pkg::NumLanes-1:0] hits,
  output lsp_pkg::merge_res_t          res
);
  import lsp_pkg::*;

  logic       light_r;
  logic       light_nxt;
  merge_res_t res_r;
  merge_res_t res_nxt;
  logic [7:0] raw_pat;
  logic [7:0] pat;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      raw_pat[i] = mirror ? hits[i] : hits[NumLanes-1-i];
    end
  end

  always_comb begin
    light_nxt = light_r;
    if (load) begin
      if (is_dark_pat(raw_pat)) begin
        light_nxt = 1'b0;
      end else if (is_light_pat(raw_pat)) begin
        light_nxt = 1'b1;
      end
    end
  end

  assign pat = light_nxt ? ~raw_pat : raw_pat;

  always_comb begin
    logic signed [SumW-1:0] s;
    logic [CntW-1:0]        c;
    s = '0;
    c = '0;
    for (int i = 0; i < NumLanes; i++) begin
      if (pat[i]) begin
        s = s + bit_weight(3'(i));
        c = c + 1'b1;
      end
    end
    res_nxt.pattern = pat;
    res_nxt.sum     = s;
    res_nxt.count   = c;
    res_nxt.light   = light_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r <= 1'b0;
    end else begin
      light_r <= light_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ----- rtl/core/lsp_div.sv -----
// ----------------------------------------------------------------------------
// lsp_div: iterative signed divider
// restoring division of the weight sum by the hit count, one bit a cycle
// ----------------------------------------------------------------------------
module lsp_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [lsp_pkg::SumW-1:0] num,
  input  logic [lsp_pkg::DenW-1:0]        den,
  output logic                            done,
  output logic signed [lsp_pkg::SumW-1:0] quot
);
  import lsp_pkg::*;

  localparam logic [2:0] LastStep = 3'(MagW - 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [2:0]      step_r, step_nxt;
  logic            neg_r, neg_nxt;
  logic [DenW-1:0] den_r, den_nxt;
  logic [DenW-1:0] rem_r, rem_nxt;
  logic [MagW-1:0] quo_r, quo_nxt;
  logic [DenW:0]   rem_shift;
  logic [DenW:0]   rem_sub;
  logic [SumW-1:0] abs_num;

  assign abs_num   = num[SumW-1] ? (~num + 1'b1) : num;
  assign rem_shift = {rem_r, quo_r[MagW-1]};
  assign rem_sub   = rem_shift - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      neg_nxt  = num[SumW-1];
      den_nxt  = den;
      rem_nxt  = '0;
      quo_nxt  = abs_num[MagW-1:0];
    end else if (busy_r) begin
      if (rem_shift >= {1'b0, den_r}) begin
        rem_nxt = rem_sub[DenW-1:0];
        quo_nxt = {quo_r[MagW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_shift[DenW-1:0];
        quo_nxt = {quo_r[MagW-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == LastStep) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  // truncation toward zero: divide magnitudes, then restore the sign
  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

// ----- rtl/core/line_sensor_position.sv -----
// path: a scan passes the lane registers, the merge register and, when the pattern has one to seven
// line bits, the 7-step divider before the output register; empty or full patterns skip the divider
// flow: one scan at a time; a new scan is taken only after the previous one is written to the output
// register, where the previous result may still wait for the sink
// reset: thresholds 512 and 16384, mirrored order, dark line assumed, no result pending
// ----------------------------------------------------------------------------
// line_sensor_position: line follower position from eight sensors
// eight compare lanes, a merge stage with background tracking, and a
// serial divider that forms the weighted mean steering error
// ----------------------------------------------------------------------------
module line_sensor_position (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [14:0]                      cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [9:0]                       in_outer_left_sample,
  input  logic [9:0]                       in_inner_left_sample,
  input  logic signed [15:0]               in_adc_sample_a,
  input  logic signed [15:0]               in_adc_sample_b,
  input  logic signed [15:0]               in_adc_sample_c,
  input  logic signed [15:0]               in_adc_sample_d,
  input  logic [9:0]                       in_inner_right_sample,
  input  logic [9:0]                       in_outer_right_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_line_pattern,
  output logic signed [lsp_pkg::ErrW-1:0]  out_steer_error,
  output logic                             out_line_lost,
  output logic                             out_stop_box,
  output logic                             out_light_line
);
  import lsp_pkg::*;

  logic [9:0]  direct_thr_r;
  logic [14:0] adc_thr_r;
  logic        mirror_r;

  state_t state_r, state_nxt;

  logic                          in_fire;
  logic                          merge_load;
  logic                          div_start;
  logic                          div_done;
  logic signed [SumW-1:0]        div_quot;
  logic                          out_load;
  logic [NumLanes-1:0]           hits;
  merge_res_t                    mres;
  logic signed [SampleW-1:0]     lane_sample [NumLanes];
  logic signed [SampleW-1:0]     lane_thr [NumLanes];
  logic signed [SampleW-1:0]     direct_thr_x;
  logic signed [SampleW-1:0]     adc_thr_x;
  logic                          pat_zero;
  logic                          pat_full;
  logic signed [ErrW-1:0]        err_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_pat_r;
  logic signed [ErrW-1:0]        out_err_r;
  logic                          out_lost_r;
  logic                          out_stop_r;
  logic                          out_light_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direct_thr_r <= DirectThrRst;
      adc_thr_r    <= AdcThrRst;
      mirror_r     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegDirectThr: direct_thr_r <= cfg_wdata[9:0];
        RegAdcThr:    adc_thr_r    <= cfg_wdata;
        RegMirror:    mirror_r     <= cfg_wdata[0];
        default:      ;
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign direct_thr_x = $signed({7'd0, direct_thr_r});
  assign adc_thr_x    = $signed({2'd0, adc_thr_r});

  always_comb begin
    lane_sample[0] = $signed({7'd0, in_outer_left_sample});
    lane_sample[1] = $signed({7'd0, in_inner_left_sample});
    lane_sample[2] = $signed({in_adc_sample_a[15], in_adc_sample_a});
    lane_sample[3] = $signed({in_adc_sample_b[15], in_adc_sample_b});
    lane_sample[4] = $signed({in_adc_sample_c[15], in_adc_sample_c});
    lane_sample[5] = $signed({in_adc_sample_d[15], in_adc_sample_d});
    lane_sample[6] = $signed({7'd0, in_inner_right_sample});
    lane_sample[7] = $signed({7'd0, in_outer_right_sample});
    for (int i = 0; i < NumLanes; i++) begin
      lane_thr[i] = (i < 2 || i > 5) ? direct_thr_x : adc_thr_x;
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    lsp_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .load      (in_fire),
      .sample    (lane_sample[g]),
      .threshold (lane_thr[g]),
      .hit       (hits[g])
    );
  end

  lsp_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (merge_load),
    .mirror (mirror_r),
    .hits   (hits),
    .res    (mres)
  );

  lsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mres.sum),
    .den   (mres.count[DenW-1:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign pat_zero = (mres.pattern == 8'h00);
  assign pat_full = (mres.pattern == 8'hFF);

  always_comb begin
    state_nxt  = state_r;
    merge_load = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        merge_load = 1'b1;
        state_nxt  = ST_DIV_START;
      end
      ST_DIV_START: begin
        // empty and full patterns need no division
        if (pat_zero || pat_full) begin
          state_nxt = ST_WRITE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    if (pat_zero) begin
      err_nxt = ErrNone;
    end else if (pat_full) begin
      err_nxt = ErrAll;
    end else begin
      err_nxt = ErrW'(div_quot);
    end
  end

  // output register, holds the beat until the sink takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pat_r   <= mres.pattern;
      out_err_r   <= err_nxt;
      out_lost_r  <= pat_zero;
      out_stop_r  <= pat_full;
      out_light_r <= mres.light;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_line_pattern = out_pat_r;
  assign out_steer_error  = out_err_r;
  assign out_line_lost    = out_lost_r;
  assign out_stop_box     = out_stop_r;
  assign out_light_line   = out_light_r;

endmodule
